// ===== sv/assert_macros.svh =====
// Assertion macros shared by the annealing tour step modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ATS_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("annealing tour step assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ATS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("annealing tour step assertion failed");

`endif

// ===== sv/ats_pkg.sv =====
// Types and constants shared by the annealing tour step modules.
`timescale 1ns / 1ps

package ats_pkg;

    localparam int KIND_W   = 3;
    localparam int MOVE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CITY_W   = 8;
    localparam int DIST_W   = 24;
    localparam int TOTAL_W  = 32;
    localparam int TEMP_W   = 32;
    localparam int UNI_W    = 16;
    localparam int COOL_W   = 16;
    localparam int STEPS_W  = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_DIST  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TOUR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STEP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;

    // Move codes; the unused code behaves as a swap.
    localparam logic [MOVE_W-1:0] MOVE_SWAP    = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_REVERSE = 2'd1;
    localparam logic [MOVE_W-1:0] MOVE_INSERT  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_TEMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLING   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS     = 2'd3;

    // Configuration reset values.
    localparam logic [TEMP_W-1:0]  INIT_TEMP_RST = 32'd65536000;
    localparam logic [TEMP_W-1:0]  MIN_TEMP_RST  = 32'd65536;
    localparam logic [COOL_W-1:0]  COOLING_RST   = 16'd64225;
    localparam logic [STEPS_W-1:0] STEPS_RST     = 20'd10000;

    // Exponential approximation: quotient bits and number of squarings.
    localparam int DIV_ITERS = 16;
    localparam int EXP_SQUARINGS = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decode;
        logic dist_wr;
        logic tour_load;
        logic city_cap;
        logic cnt_clr;
        logic copy_run;
        logic copy_to_acc;
        logic len_run;
        logic len_src_acc;
        logic start_set;
        logic move_init;
        logic pair_rd_b;
        logic pair_wr_a;
        logic pair_wr_b;
        logic pair_next;
        logic eval;
        logic div_run;
        logic exp_run;
        logic accept_cap;
        logic cool;
        logic out_load;
    } ats_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic item_ok;
        logic copy_done;
        logic len_done;
        logic pair_more;
        logic shorter;
        logic exp_zero;
        logic div_done;
        logic exp_done;
        logic accept;
        logic out_free;
    } ats_stat_t;

endpackage

// ===== sv/ats_ctrl.sv =====
// Controller state machine that sequences each request through the datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ats_ctrl import ats_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ats_stat_t stat,
    output ats_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DECODE    = 5'd1;
    localparam logic [4:0] S_RD_WAIT   = 5'd2;
    localparam logic [4:0] S_CP_RUN    = 5'd3;
    localparam logic [4:0] S_LEN_RUN   = 5'd4;
    localparam logic [4:0] S_START_SET = 5'd5;
    localparam logic [4:0] S_MV_CHK    = 5'd6;
    localparam logic [4:0] S_P0        = 5'd7;
    localparam logic [4:0] S_P1        = 5'd8;
    localparam logic [4:0] S_P2        = 5'd9;
    localparam logic [4:0] S_P3        = 5'd10;
    localparam logic [4:0] S_EVAL      = 5'd11;
    localparam logic [4:0] S_BRANCH    = 5'd12;
    localparam logic [4:0] S_DIV_RUN   = 5'd13;
    localparam logic [4:0] S_EXP_RUN   = 5'd14;
    localparam logic [4:0] S_DECIDE    = 5'd15;
    localparam logic [4:0] S_ACPY      = 5'd16;
    localparam logic [4:0] S_COOL      = 5'd17;
    localparam logic [4:0] S_RESULT    = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       is_start;

    assign is_start = (stat.kind == KIND_START);
    assign s_ready  = (state_reg == S_IDLE);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                cmd.cnt_clr = 1'b1;
                state_next = S_RESULT;
                case (stat.kind)
                    KIND_DIST: begin
                        cmd.dist_wr = stat.item_ok;
                    end
                    KIND_TOUR: begin
                        cmd.tour_load = stat.item_ok;
                    end
                    KIND_START: begin
                        state_next = S_CP_RUN;
                    end
                    KIND_STEP: begin
                        if (stat.item_ok) begin
                            cmd.move_init = 1'b1;
                            state_next = S_MV_CHK;
                        end
                    end
                    KIND_READ: begin
                        if (stat.item_ok) begin
                            state_next = S_RD_WAIT;
                        end
                    end
                    default: begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_RD_WAIT: begin
                cmd.city_cap = 1'b1;
                state_next = S_RESULT;
            end
            S_CP_RUN: begin
                cmd.copy_run = 1'b1;
                if (stat.copy_done) begin
                    cmd.cnt_clr = 1'b1;
                    state_next = S_LEN_RUN;
                end
            end
            S_LEN_RUN: begin
                cmd.len_run = 1'b1;
                cmd.len_src_acc = is_start;
                if (stat.len_done) begin
                    cmd.cnt_clr = 1'b1;
                    state_next = is_start ? S_START_SET : S_EVAL;
                end
            end
            S_START_SET: begin
                cmd.start_set = 1'b1;
                state_next = S_RESULT;
            end
            S_MV_CHK: begin
                if (stat.pair_more) begin
                    state_next = S_P0;
                end else begin
                    cmd.cnt_clr = 1'b1;
                    state_next = S_LEN_RUN;
                end
            end
            S_P0: begin
                state_next = S_P1;
            end
            S_P1: begin
                cmd.pair_rd_b = 1'b1;
                state_next = S_P2;
            end
            S_P2: begin
                cmd.pair_wr_a = 1'b1;
                state_next = S_P3;
            end
            S_P3: begin
                cmd.pair_wr_b = 1'b1;
                cmd.pair_next = 1'b1;
                state_next = S_MV_CHK;
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                cmd.cnt_clr = 1'b1;
                state_next = S_BRANCH;
            end
            S_BRANCH: begin
                state_next = (stat.shorter || stat.exp_zero) ? S_DECIDE : S_DIV_RUN;
            end
            S_DIV_RUN: begin
                cmd.div_run = 1'b1;
                if (stat.div_done) begin
                    cmd.cnt_clr = 1'b1;
                    state_next = S_EXP_RUN;
                end
            end
            S_EXP_RUN: begin
                cmd.exp_run = 1'b1;
                if (stat.exp_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.accept_cap = 1'b1;
                cmd.cnt_clr = 1'b1;
                state_next = stat.accept ? S_ACPY : S_COOL;
            end
            S_ACPY: begin
                cmd.copy_run = 1'b1;
                cmd.copy_to_acc = 1'b1;
                if (stat.copy_done) begin
                    state_next = S_COOL;
                end
            end
            S_COOL: begin
                cmd.cool = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ATS_ASSERT_NEXT(a_accept_to_decode, state_reg == S_IDLE && s_valid, state_reg == S_DECODE)
    `ATS_ASSERT_IMPLIES(a_out_load_free, cmd.out_load, stat.out_free)
    `ATS_ASSERT_NEXT(a_len_exit, state_reg == S_LEN_RUN && stat.len_done, state_reg == S_START_SET || state_reg == S_EVAL)

endmodule

// ===== sv/ats_dp.sv =====
// Datapath: tour and distance memories, length accumulator, exponential unit and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ats_dp import ats_pkg::*; #(
    parameter int NUM_CITIES = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [KIND_W-1:0]     in_kind,
    input  logic [CITY_W-1:0]     in_first_index,
    input  logic [CITY_W-1:0]     in_second_index,
    input  logic [DIST_W-1:0]     in_value,
    input  logic [MOVE_W-1:0]     in_move,
    input  logic [UNI_W-1:0]      in_uniform,
    input  ats_cmd_t              cmd,
    output ats_stat_t             stat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   out_status,
    output logic                  out_accepted,
    output logic [TOTAL_W-1:0]    out_accepted_length,
    output logic [TOTAL_W-1:0]    out_candidate_length,
    output logic                  out_finished,
    output logic [CITY_W-1:0]     out_read_city
);

    localparam int IDX_W = $clog2(NUM_CITIES);
    localparam int CNT_W = (NUM_CITIES + 3 > 17) ? $clog2(NUM_CITIES + 3) : 5;
    localparam int DIST_DEPTH = 1 << (2 * IDX_W);
    localparam logic [CNT_W-1:0] CNT_N  = CNT_W'(NUM_CITIES);
    localparam logic [CNT_W-1:0] CNT_N1 = CNT_W'(NUM_CITIES + 1);
    localparam logic [CNT_W-1:0] CNT_N2 = CNT_W'(NUM_CITIES + 2);
    localparam logic [CNT_W-1:0] CNT_DIV_LAST = CNT_W'(DIV_ITERS - 1);
    localparam logic [CNT_W-1:0] CNT_EXP_LAST = CNT_W'(EXP_SQUARINGS - 1);
    localparam logic [CITY_W:0]  CITY_LIMIT = (CITY_W + 1)'(NUM_CITIES);

    // Configuration registers.
    logic [TEMP_W-1:0]  init_temp_reg;
    logic [TEMP_W-1:0]  min_temp_reg;
    logic [COOL_W-1:0]  cooling_reg;
    logic [STEPS_W-1:0] steps_reg;

    // Captured request.
    logic [KIND_W-1:0]  kind_reg;
    logic [CITY_W-1:0]  i1_reg;
    logic [CITY_W-1:0]  i2_reg;
    logic [DIST_W-1:0]  value_reg;
    logic [MOVE_W-1:0]  move_reg;
    logic [UNI_W-1:0]   uni_reg;

    // Run state.
    logic [TOTAL_W-1:0] acc_total_reg;
    logic [TOTAL_W-1:0] cand_total_reg;
    logic [TEMP_W-1:0]  temp_reg;
    logic [STEPS_W-1:0] stage_cnt_reg;

    // Sequencing registers.
    logic [CNT_W-1:0]  j_reg;
    logic [IDX_W-1:0]  a_reg;
    logic [IDX_W-1:0]  b_reg;
    logic [IDX_W-1:0]  lo_reg;
    logic [CITY_W-1:0] tmp_reg;

    // Memories and their read registers.
    logic [CITY_W-1:0] cand_mem [NUM_CITIES];
    logic [CITY_W-1:0] acc_mem  [NUM_CITIES];
    logic [DIST_W-1:0] dist_mem [DIST_DEPTH];
    logic [CITY_W-1:0] cand_rd_reg;
    logic [CITY_W-1:0] acc_rd_reg;
    logic [DIST_W-1:0] dist_rd_reg;

    // Length pipeline.
    logic [CITY_W-1:0]  first_city_reg;
    logic [CITY_W-1:0]  prev_city_reg;
    logic               dv_reg;
    logic               dz_reg;
    logic [TOTAL_W-1:0] sum_reg;

    // Exponential unit.
    logic                shorter_reg;
    logic                zero_reg;
    logic [TEMP_W:0]     rem_reg;
    logic [UNI_W-1:0]    quo_reg;
    logic [UNI_W:0]      y_reg;
    logic                acc_flag_reg;

    // Result register.
    logic [STATUS_W-1:0] status_reg;
    logic [CITY_W-1:0]   city_reg;

    // Combinational helpers.
    logic                i1_ok;
    logic                i2_ok;
    logic                finished;
    logic [STATUS_W-1:0] item_status;
    logic [IDX_W-1:0]    p_lo;
    logic [IDX_W-1:0]    p_hi;
    logic [IDX_W-1:0]    jm1;
    logic [IDX_W-1:0]    cand_raddr;
    logic [IDX_W-1:0]    acc_raddr;
    logic                cand_we;
    logic [IDX_W-1:0]    cand_waddr;
    logic [CITY_W-1:0]   cand_wdata;
    logic                acc_we;
    logic [IDX_W-1:0]    acc_waddr;
    logic [CITY_W-1:0]   acc_wdata;
    logic [CITY_W-1:0]   src_city;
    logic                len_close;
    logic                len_pair;
    logic [CITY_W-1:0]   pair_from;
    logic [CITY_W-1:0]   pair_to;
    logic [2*IDX_W-1:0]  dist_raddr;
    logic [TOTAL_W:0]    sum_ext;
    logic [TOTAL_W-1:0]  delta;
    logic [TEMP_W:0]     rem_dbl;
    logic [UNI_W:0]      y_src;
    logic [2*UNI_W+1:0]  y_sq;
    logic [UNI_W-1:0]    y_cap;
    logic                accept;
    logic [STEPS_W-1:0]  stage_inc;
    logic [TEMP_W+COOL_W-1:0] cool_prod;

    // Request checks.
    assign i1_ok = ({1'b0, i1_reg} < CITY_LIMIT);
    assign i2_ok = ({1'b0, i2_reg} < CITY_LIMIT);
    assign finished = (temp_reg <= min_temp_reg);

    always_comb begin
        case (kind_reg)
            KIND_DIST:  item_status = (i1_ok && i2_ok) ? ST_OK : ST_BAD;
            KIND_TOUR:  item_status = i1_ok ? ST_OK : ST_BAD;
            KIND_START: item_status = ST_OK;
            KIND_STEP: begin
                if (finished) begin
                    item_status = ST_DONE;
                end else if (i1_ok && i2_ok && (i1_reg != i2_reg)) begin
                    item_status = ST_OK;
                end else begin
                    item_status = ST_BAD;
                end
            end
            KIND_READ:  item_status = i1_ok ? ST_OK : ST_BAD;
            default:    item_status = ST_BAD;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_temp_reg <= INIT_TEMP_RST;
            min_temp_reg  <= MIN_TEMP_RST;
            cooling_reg   <= COOLING_RST;
            steps_reg     <= STEPS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_INIT_TEMP: init_temp_reg <= cfg_wr_data;
                CFG_MIN_TEMP:  min_temp_reg  <= cfg_wr_data;
                CFG_COOLING:   cooling_reg   <= cfg_wr_data[COOL_W-1:0];
                CFG_STEPS:     steps_reg     <= cfg_wr_data[STEPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_DIST;
        end else if (cmd.capture) begin
            kind_reg <= in_kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            i1_reg    <= in_first_index;
            i2_reg    <= in_second_index;
            value_reg <= in_value;
            move_reg  <= in_move;
            uni_reg   <= in_uniform;
        end
    end

    // Shared sequence counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_reg <= '0;
        end else if (cmd.cnt_clr) begin
            j_reg <= '0;
        end else if (cmd.copy_run || cmd.len_run || cmd.div_run || cmd.exp_run) begin
            j_reg <= j_reg + 1'b1;
        end
    end

    assign jm1 = IDX_W'(j_reg - 1'b1);

    // Move pointers: every move is a series of two-entry exchanges.
    assign p_lo = (i1_reg < i2_reg) ? i1_reg[IDX_W-1:0] : i2_reg[IDX_W-1:0];
    assign p_hi = (i1_reg < i2_reg) ? i2_reg[IDX_W-1:0] : i1_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.move_init) begin
            lo_reg <= p_lo;
            case (move_reg)
                MOVE_REVERSE: begin
                    a_reg <= p_lo;
                    b_reg <= p_hi - 1'b1;
                end
                MOVE_INSERT: begin
                    a_reg <= p_hi - 1'b1;
                    b_reg <= p_hi;
                end
                default: begin
                    a_reg <= p_lo;
                    b_reg <= p_hi;
                end
            endcase
        end else if (cmd.pair_next) begin
            case (move_reg)
                MOVE_REVERSE: begin
                    a_reg <= a_reg + 1'b1;
                    b_reg <= b_reg - 1'b1;
                end
                MOVE_INSERT: begin
                    a_reg <= a_reg - 1'b1;
                    b_reg <= b_reg - 1'b1;
                end
                default: begin
                    a_reg <= b_reg;
                end
            endcase
        end
        if (cmd.pair_rd_b) begin
            tmp_reg <= cand_rd_reg;
        end
    end

    // Tour memory ports.
    assign cand_raddr = cmd.pair_rd_b ? b_reg :
                        (cmd.copy_run || cmd.len_run) ? j_reg[IDX_W-1:0] : a_reg;
    assign acc_raddr  = (cmd.copy_run || cmd.len_run) ? j_reg[IDX_W-1:0] : i1_reg[IDX_W-1:0];

    assign cand_we = cmd.pair_wr_a || cmd.pair_wr_b ||
                     (cmd.copy_run && !cmd.copy_to_acc && (j_reg != '0));
    assign cand_waddr = cmd.pair_wr_a ? a_reg : cmd.pair_wr_b ? b_reg : jm1;
    assign cand_wdata = cmd.pair_wr_a ? cand_rd_reg : cmd.pair_wr_b ? tmp_reg : acc_rd_reg;

    assign acc_we = cmd.tour_load || (cmd.copy_run && cmd.copy_to_acc && (j_reg != '0));
    assign acc_waddr = cmd.tour_load ? i1_reg[IDX_W-1:0] : jm1;
    assign acc_wdata = cmd.tour_load ? value_reg[CITY_W-1:0] : cand_rd_reg;

    always_ff @(posedge aclk) begin
        if (cand_we) begin
            cand_mem[cand_waddr] <= cand_wdata;
        end
        cand_rd_reg <= cand_mem[cand_raddr];
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rd_reg <= acc_mem[acc_raddr];
    end

    // Distance memory: row and column concatenated into the address.
    assign src_city  = cmd.len_src_acc ? acc_rd_reg : cand_rd_reg;
    assign len_close = (j_reg == CNT_N1);
    assign len_pair  = cmd.len_run && (len_close ||
                       ((j_reg >= CNT_W'(2)) && (j_reg <= CNT_N)));
    assign pair_from = prev_city_reg;
    assign pair_to   = len_close ? first_city_reg : src_city;
    assign dist_raddr = {pair_from[IDX_W-1:0], pair_to[IDX_W-1:0]};

    always_ff @(posedge aclk) begin
        if (cmd.dist_wr) begin
            dist_mem[{i1_reg[IDX_W-1:0], i2_reg[IDX_W-1:0]}] <= value_reg;
        end
        dist_rd_reg <= dist_mem[dist_raddr];
    end

    // Length accumulation over the closed tour, saturating.
    assign sum_ext = {1'b0, sum_reg} + (TOTAL_W + 1)'(dz_reg ? '0 : dist_rd_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= 1'b0;
        end else begin
            dv_reg <= len_pair;
        end
    end

    always_ff @(posedge aclk) begin
        dz_reg <= !(({1'b0, pair_from} < CITY_LIMIT) && ({1'b0, pair_to} < CITY_LIMIT));
        if (cmd.len_run && (j_reg == CNT_W'(1))) begin
            first_city_reg <= src_city;
            prev_city_reg  <= src_city;
        end else if (len_pair && !len_close) begin
            prev_city_reg <= src_city;
        end
        if (cmd.len_run && (j_reg == '0)) begin
            sum_reg <= '0;
        end else if (dv_reg) begin
            sum_reg <= sum_ext[TOTAL_W] ? '1 : sum_ext[TOTAL_W-1:0];
        end
    end

    // Acceptance test: ratio by restoring division, then repeated squaring.
    assign delta   = sum_reg - acc_total_reg;
    assign rem_dbl = {rem_reg[TEMP_W-1:0], 1'b0};
    assign y_src   = (j_reg == '0) ? ((UNI_W + 1)'(1 << UNI_W) - {1'b0, quo_reg}) : y_reg;
    assign y_sq    = y_src * y_src;
    assign y_cap   = y_reg[UNI_W] ? '1 : y_reg[UNI_W-1:0];
    assign accept  = shorter_reg || (!zero_reg && (y_cap > uni_reg));

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            shorter_reg <= (sum_reg < acc_total_reg);
            zero_reg    <= ({delta, 4'b0} >= {4'b0, temp_reg});
            rem_reg     <= {1'b0, delta};
            quo_reg     <= '0;
        end else if (cmd.div_run) begin
            if (rem_dbl >= {1'b0, temp_reg}) begin
                rem_reg <= rem_dbl - {1'b0, temp_reg};
                quo_reg <= {quo_reg[UNI_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_dbl;
                quo_reg <= {quo_reg[UNI_W-2:0], 1'b0};
            end
        end
        if (cmd.exp_run) begin
            y_reg <= y_sq[2*UNI_W:UNI_W] + (UNI_W + 1)'(y_sq[UNI_W-1]);
        end
    end

    // Run totals, temperature and stage count.
    assign stage_inc = stage_cnt_reg + 1'b1;
    assign cool_prod = temp_reg * cooling_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_total_reg  <= '0;
            cand_total_reg <= '0;
            temp_reg       <= '0;
            stage_cnt_reg  <= '0;
        end else begin
            if (cmd.start_set) begin
                acc_total_reg  <= sum_reg;
                cand_total_reg <= sum_reg;
                temp_reg       <= init_temp_reg;
                stage_cnt_reg  <= '0;
            end
            if (cmd.eval) begin
                cand_total_reg <= sum_reg;
            end
            if (cmd.accept_cap && accept) begin
                acc_total_reg <= cand_total_reg;
            end
            if (cmd.cool) begin
                if (stage_inc >= steps_reg) begin
                    temp_reg      <= cool_prod[TEMP_W+COOL_W-1:COOL_W];
                    stage_cnt_reg <= '0;
                end else begin
                    stage_cnt_reg <= stage_inc;
                end
            end
        end
    end

    // Per-request result fields.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            acc_flag_reg <= 1'b0;
            city_reg     <= '0;
        end else begin
            if (cmd.accept_cap) begin
                acc_flag_reg <= accept;
            end
            if (cmd.city_cap) begin
                city_reg <= acc_rd_reg;
            end
        end
        if (cmd.decode) begin
            status_reg <= item_status;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status           <= status_reg;
            out_accepted         <= acc_flag_reg;
            out_accepted_length  <= acc_total_reg;
            out_candidate_length <= cand_total_reg;
            out_finished         <= finished;
            out_read_city        <= city_reg;
        end
    end

    // Status to the controller.
    assign stat.kind      = kind_reg;
    assign stat.item_ok   = (item_status == ST_OK);
    assign stat.copy_done = (j_reg == CNT_N);
    assign stat.len_done  = (j_reg == CNT_N2);
    assign stat.pair_more = (move_reg == MOVE_INSERT) ? (b_reg > lo_reg) : (a_reg < b_reg);
    assign stat.shorter   = shorter_reg;
    assign stat.exp_zero  = zero_reg;
    assign stat.div_done  = (j_reg == CNT_DIV_LAST);
    assign stat.exp_done  = (j_reg == CNT_EXP_LAST);
    assign stat.accept    = accept;
    assign stat.out_free  = !m_valid || m_ready;

    `ATS_ASSERT_NEXT(a_out_valid_after_load, cmd.out_load, m_valid)
    `ATS_ASSERT_IMPLIES(a_div_only_when_ratio_small, cmd.div_run, !zero_reg && !shorter_reg)
    `ATS_ASSERT_NEXT(a_accept_takes_candidate, cmd.accept_cap && accept, acc_total_reg == cand_total_reg)

endmodule

// ===== sv/annealing_tour_step.sv =====
// Annealing tour step: one request in, one result out, over a sequenced tour datapath.
`timescale 1ns / 1ps

// One request is taken at a time and answered by exactly one result; the
// next request is accepted while that result waits in the output register.
// A start copies the tour and makes one pass over the distance memory, one
// distance per cycle. A step makes the entry exchanges of its move (one for
// a swap, half the span for a reversal, the span for an insertion), a
// length pass, a run of the exponential unit (16 division steps and 8
// squarings) that is skipped for a shorter tour or a large ratio, and a
// copy of an accepted tour. Each tour memory and the distance memory
// have a single read port. There is no clearing pass.
module annealing_tour_step import ats_pkg::*; #(
    parameter int NUM_CITIES = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // first_index[7:0], second_index[15:8], value[39:16], move[41:40], uniform[57:42]
    input  logic [63:0]           s_tdata,
    // kind[2:0]
    input  logic [2:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // accepted[0], accepted_length[32:1], candidate_length[64:33], finished[65],
    // read_city[73:66]
    output logic [79:0]           m_tdata,
    // status[1:0]
    output logic [1:0]            m_tuser
);

    ats_cmd_t  cmd;
    ats_stat_t stat;

    logic [STATUS_W-1:0] out_status;
    logic                out_accepted;
    logic [TOTAL_W-1:0]  out_accepted_length;
    logic [TOTAL_W-1:0]  out_candidate_length;
    logic                out_finished;
    logic [CITY_W-1:0]   out_read_city;

    ats_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ats_dp #(
        .NUM_CITIES (NUM_CITIES)
    ) u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_index         (cfg_wr_index),
        .cfg_wr_data          (cfg_wr_data),
        .in_kind              (s_tuser),
        .in_first_index       (s_tdata[7:0]),
        .in_second_index      (s_tdata[15:8]),
        .in_value             (s_tdata[39:16]),
        .in_move              (s_tdata[41:40]),
        .in_uniform           (s_tdata[57:42]),
        .cmd                  (cmd),
        .stat                 (stat),
        .m_valid              (m_tvalid),
        .m_ready              (m_tready),
        .out_status           (out_status),
        .out_accepted         (out_accepted),
        .out_accepted_length  (out_accepted_length),
        .out_candidate_length (out_candidate_length),
        .out_finished         (out_finished),
        .out_read_city        (out_read_city)
    );

    // Result packing, lowest field first.
    assign m_tuser = out_status;
    assign m_tdata = {6'b0, out_read_city, out_finished, out_candidate_length,
                      out_accepted_length, out_accepted};

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the annealing tour step block: stream driver, result monitor, predictor.
`timescale 1ns / 1ps

module tb_top import ats_pkg::*; ();

    localparam int NCITY       = 64;
    localparam int WORLD       = 6;      // cities 0..WORLD-1 have written distances
    localparam int IDLE_LIMIT  = 40000;  // cycles with no handshake before giving up
    localparam int HOLD_CYCLES = 2500;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [7:0]         first;
        logic [7:0]         second;
        logic [DIST_W-1:0]  value;
        logic [MOVE_W-1:0]  move;
        logic [UNI_W-1:0]   uniform;
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                accepted;
        logic [TOTAL_W-1:0]  acc_len;
        logic [TOTAL_W-1:0]  cand_len;
        logic                finished;
        logic [CITY_W-1:0]   city;
    } answer_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata = '0;
    logic [2:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [79:0]           m_tdata;
    logic [1:0]            m_tuser;

    annealing_tour_step #(.NUM_CITIES(NCITY)) u_top (.*);

    always #6 aclk = ~aclk;

    // Predictor state and its copy of the configuration.
    logic [DIST_W-1:0]  dist_mem [NCITY*NCITY];
    logic [CITY_W-1:0]  cand_tour [NCITY];
    logic [CITY_W-1:0]  acc_tour [NCITY];
    logic [TOTAL_W-1:0] acc_total = '0;
    logic [TOTAL_W-1:0] cand_total = '0;
    logic [TEMP_W-1:0]  temp_now = '0;
    logic [STEPS_W-1:0] stage_count = '0;
    logic [TEMP_W-1:0]  init_temp_cfg = INIT_TEMP_RST;
    logic [TEMP_W-1:0]  min_temp_cfg = MIN_TEMP_RST;
    logic [COOL_W-1:0]  cooling_cfg = COOLING_RST;
    logic [STEPS_W-1:0] steps_cfg = STEPS_RST;

    request_t pending_q[$];
    answer_t  answer_q[$];
    request_t cur_req;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  long_hold_done = 0;
    bit  quiet = 0;
    int  requests_taken = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  moves_accepted = 0;
    int  finished_results = 0;
    int  idle_cycles = 0;

    function automatic logic [DIST_W-1:0] dist_of(logic [7:0] a, logic [7:0] b);
        if (a >= NCITY || b >= NCITY) return '0;
        return dist_mem[a * NCITY + b];
    endfunction

    // Closed-loop length of the accepted or the candidate tour, saturating.
    function automatic logic [TOTAL_W-1:0] loop_length(bit use_acc);
        logic [63:0] sum;
        logic [7:0]  a, b;
        sum = 0;
        for (int j = 0; j < NCITY; j++) begin
            a = use_acc ? acc_tour[j] : cand_tour[j];
            b = use_acc ? acc_tour[(j + 1) % NCITY] : cand_tour[(j + 1) % NCITY];
            sum += dist_of(a, b);
            if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
        end
        return sum[31:0];
    endfunction

    // Approximation of exp(-256*delta/T) in Q0.16 by repeated squaring of 1 - delta/T.
    function automatic logic [31:0] exp_weight(logic [31:0] delta, logic [31:0] t);
        logic [63:0] x, y;
        x = ({32'd0, delta} << 24) / {32'd0, t};
        if (x >= 64'd1048576) return '0;
        y = 64'd65536 - (x >> 8);
        for (int k = 0; k < EXP_SQUARINGS; k++) y = (y * y + 64'd32768) >> 16;
        if (y > 64'd65535) y = 64'd65535;
        return y[31:0];
    endfunction

    // Apply one request to the predictor state and queue its answer.
    task automatic model_request(input request_t r);
        answer_t     ans;
        int          p1, p2, a, b;
        logic [7:0]  tmp;
        logic [63:0] prod;
        ans = '{ST_OK, 1'b0, '0, '0, 1'b0, '0};
        case (r.kind)
            KIND_DIST: begin
                if (r.first < NCITY && r.second < NCITY) dist_mem[r.first * NCITY + r.second] = r.value;
                else ans.status = ST_BAD;
            end
            KIND_TOUR: begin
                if (r.first < NCITY) acc_tour[r.first] = r.value[7:0];
                else ans.status = ST_BAD;
            end
            KIND_START: begin
                cand_tour = acc_tour;
                acc_total = loop_length(1);
                cand_total = acc_total;
                temp_now = init_temp_cfg;
                stage_count = '0;
            end
            KIND_STEP: begin
                if (temp_now <= min_temp_cfg) ans.status = ST_DONE;
                else if (r.first >= NCITY || r.second >= NCITY || r.first == r.second)
                    ans.status = ST_BAD;
                else begin
                    p1 = (r.first < r.second) ? r.first : r.second;
                    p2 = (r.first < r.second) ? r.second : r.first;
                    if (r.move == MOVE_REVERSE) begin
                        a = p1;
                        b = p2 - 1;
                        while (a < b) begin
                            tmp = cand_tour[a];
                            cand_tour[a] = cand_tour[b];
                            cand_tour[b] = tmp;
                            a++;
                            b--;
                        end
                    end else if (r.move == MOVE_INSERT) begin
                        tmp = cand_tour[p2];
                        for (int k = p2; k > p1; k--) cand_tour[k] = cand_tour[k - 1];
                        cand_tour[p1] = tmp;
                    end else begin
                        // The spare move code is a swap as well.
                        tmp = cand_tour[p1];
                        cand_tour[p1] = cand_tour[p2];
                        cand_tour[p2] = tmp;
                    end
                    cand_total = loop_length(0);
                    if (cand_total < acc_total) ans.accepted = 1'b1;
                    else if (exp_weight(cand_total - acc_total, temp_now) > r.uniform)
                        ans.accepted = 1'b1;
                    if (ans.accepted) begin
                        acc_tour = cand_tour;
                        acc_total = cand_total;
                        moves_accepted++;
                    end
                    stage_count = stage_count + 1'b1;
                    if (stage_count >= steps_cfg) begin
                        prod = {32'd0, temp_now} * {48'd0, cooling_cfg};
                        temp_now = prod[47:16];
                        stage_count = '0;
                    end
                end
            end
            KIND_READ: begin
                if (r.first < NCITY) ans.city = acc_tour[r.first];
                else ans.status = ST_BAD;
            end
            default: ans.status = ST_BAD;
        endcase
        ans.acc_len = acc_total;
        ans.cand_len = cand_total;
        ans.finished = (temp_now <= min_temp_cfg);
        answer_q.insert(answer_q.size(), ans);
    endtask

    // Request driver: takes the next pending request whenever the slot is free.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                model_request(cur_req);
                requests_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    cur_req = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'd0, cur_req.uniform, cur_req.move, cur_req.value,
                                cur_req.second, cur_req.first};
                    s_tuser <= cur_req.kind;
                    if (!quiet && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 17);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each result against the oldest prediction.
    always @(posedge aclk) begin
        answer_t want, got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                got.status = m_tuser;
                got.accepted = m_tdata[0];
                got.acc_len = m_tdata[32:1];
                got.cand_len = m_tdata[64:33];
                got.finished = m_tdata[65];
                got.city = m_tdata[73:66];
                if (got.finished) finished_results++;
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("ERROR: result with no request pending");
                end else begin
                    want = answer_q.pop_front();
                    if (want.status !== got.status || want.accepted !== got.accepted
                        || want.acc_len !== got.acc_len || want.cand_len !== got.cand_len
                        || want.finished !== got.finished || want.city !== got.city) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d exp st=%0d acc=%0d alen=%0h clen=%0h fin=%0d city=%0d got st=%0d acc=%0d alen=%0h clen=%0h fin=%0d city=%0d",
                                     results_seen, want.status, want.accepted, want.acc_len,
                                     want.cand_len, want.finished, want.city, got.status,
                                     got.accepted, got.acc_len, got.cand_len, got.finished,
                                     got.city);
                    end
                end
            end
            // Receiver stalls: short random bursts, and one long hold to back up the block.
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 200) begin
                long_hold_done = 1;
                stall_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 17);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic add_req(input logic [2:0] kind, input logic [7:0] first,
                           input logic [7:0] second, input logic [23:0] value,
                           input logic [1:0] move, input logic [15:0] uniform);
        request_t r;
        r = '{kind, first, second, value, move, uniform};
        pending_q.insert(pending_q.size(), r);
    endtask

    function automatic logic [7:0] pick_pos();
        return ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, NCITY - 1));
    endfunction

    function automatic logic [23:0] pick_city_value();
        logic [7:0] city;
        city = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(NCITY, 255))
                                            : 8'($urandom_range(0, WORLD - 1));
        return {16'($urandom), city};
    endfunction

    function automatic logic [23:0] pick_distance();
        return ($urandom_range(0, 15) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h3FFFF));
    endfunction

    // Mostly anneal steps, with reads, table reloads, tour edits, restarts and stray requests.
    task automatic queue_random(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                add_req(KIND_STEP, pick_pos(), pick_pos(), 24'($urandom),
                        2'($urandom_range(0, 3)), 16'($urandom));
            else if (pick < 82)
                add_req(KIND_READ, pick_pos(), 8'($urandom), 24'($urandom),
                        2'($urandom), 16'($urandom));
            else if (pick < 88)
                add_req(KIND_DIST,
                        ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, WORLD - 1)),
                        8'($urandom_range(0, WORLD - 1)), pick_distance(), 2'($urandom), 16'($urandom));
            else if (pick < 93)
                add_req(KIND_TOUR, pick_pos(), 8'($urandom), pick_city_value(),
                        2'($urandom), 16'($urandom));
            else if (pick < 96)
                add_req(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom), 24'($urandom),
                        2'($urandom), 16'($urandom));
            else
                add_req(KIND_START, 8'($urandom), 8'($urandom), 24'($urandom),
                        2'($urandom), 16'($urandom));
        end
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic drain();
        while (pending_q.size() > 0 || s_tvalid || answer_q.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_config(input logic [31:0] t0, input logic [31:0] tmin,
                                input logic [15:0] cool, input logic [19:0] steps);
        logic [31:0] vals [4];
        logic [1:0]  idx [4];
        vals = '{t0, tmin, {16'd0, cool}, {12'd0, steps}};
        idx = '{CFG_INIT_TEMP, CFG_MIN_TEMP, CFG_COOLING, CFG_STEPS};
        for (int k = 0; k < 4; k++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_wr_index <= idx[k];
            cfg_wr_data <= vals[k];
        end
        init_temp_cfg = t0;
        min_temp_cfg = tmin;
        cooling_cfg = cool;
        steps_cfg = steps;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic start_phase(input int count);
        add_req(KIND_START, '0, '0, '0, MOVE_SWAP, '0);
        queue_random(count);
        drain();
    endtask

    // Stimulus sequence.
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Distance table over the small city set, extremes included.
        for (int r = 0; r < WORLD; r++)
            for (int c = 0; c < WORLD; c++)
                add_req(KIND_DIST, 8'(r), 8'(c), pick_distance(), 2'($urandom), 16'($urandom));
        add_req(KIND_DIST, 8'd1, 8'd2, 24'hFFFFFF, MOVE_SWAP, 16'hFFFF);
        add_req(KIND_DIST, 8'd2, 8'd1, 24'h000000, MOVE_SWAP, 16'h0000);
        // Initial tour; one entry holds a city number past the table.
        for (int p = 0; p < NCITY; p++)
            add_req(KIND_TOUR, 8'(p), '0, (p == 17) ? 24'hFFFFC3 : pick_city_value(),
                    MOVE_SWAP, '0);

        // Directed corner requests.
        add_req(3'd5, 8'hFF, 8'hFF, 24'hFFFFFF, 2'd3, 16'hFFFF);
        add_req(3'd7, '0, '0, '0, MOVE_SWAP, '0);
        add_req(KIND_DIST, 8'd64, 8'd3, 24'h123456, MOVE_SWAP, '0);
        add_req(KIND_DIST, 8'd3, 8'd255, 24'h123456, MOVE_SWAP, '0);
        add_req(KIND_TOUR, 8'd200, '0, 24'h000001, MOVE_SWAP, '0);
        add_req(KIND_READ, 8'd64, '0, '0, MOVE_SWAP, '0);
        add_req(KIND_STEP, 8'd1, 8'd2, '0, MOVE_SWAP, 16'h8000);
        add_req(KIND_START, '0, '0, '0, MOVE_SWAP, '0);
        add_req(KIND_STEP, 8'd0, 8'd63, '0, MOVE_SWAP, 16'h0000);
        add_req(KIND_STEP, 8'd40, 8'd3, '0, MOVE_REVERSE, 16'hFFFF);
        add_req(KIND_STEP, 8'd10, 8'd50, '0, MOVE_INSERT, 16'h0000);
        add_req(KIND_STEP, 8'd63, 8'd0, '0, 2'd3, 16'h7FFF);
        add_req(KIND_STEP, 8'd5, 8'd6, '0, MOVE_REVERSE, 16'h0001);
        add_req(KIND_STEP, 8'd5, 8'd5, '0, MOVE_SWAP, '0);
        add_req(KIND_STEP, 8'd70, 8'd3, '0, MOVE_INSERT, '0);
        add_req(KIND_STEP, 8'd3, 8'd255, '0, MOVE_REVERSE, '0);
        add_req(KIND_READ, 8'd0, '0, '0, MOVE_SWAP, '0);
        add_req(KIND_READ, 8'd63, 8'hFF, 24'hFFFFFF, 2'd3, 16'hFFFF);
        queue_random(350);
        drain();

        // Configuration sweeps, extremes first, the last one with no idling.
        write_config(32'hFFFF_FFFF, 32'd0, 16'hFFFF, 20'hFFFFF);
        start_phase(200);
        write_config(32'd1, 32'd0, 16'd1, 20'd1);
        start_phase(150);
        write_config(32'd3276800, 32'd65536, 16'd32768, 20'd3);
        start_phase(220);
        write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd40000, 20'd2);
        start_phase(100);
        write_config(32'd655360, 32'd1000, 16'd60000, 20'd5);
        quiet = 1;
        start_phase(250);

        $display("Run covered %0d requests and %0d results over six configurations,",
                 requests_taken, results_seen);
        $display("with %0d accepted moves and %0d results reporting a finished run.",
                 moves_accepted, finished_results);
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
